// ===== rtl/ctrie_pkg.sv =====
// Shared types and constants for the counted trie engine.
// Depends on nothing; imported by every module of the block.
package ctrie_pkg;

   localparam int NODES_DEF      = 4096;
   localparam int ALPHABET_DEF   = 26;
   localparam int COUNT_BITS_DEF = 16;

   localparam int CMD_W    = 2;
   localparam int LETTER_W = 5;
   localparam int WCOUNT_W = 16;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic clear;
      logic count;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic alloc;
      logic last;
      logic live;
   } dp_status_type;

endpackage

// ===== rtl/ctrie_ctrl.sv =====
// Controller of the counted trie engine: sequences lookup, node clear,
// count update and result hand-off. Depends on ctrie_pkg.
module ctrie_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  ctrie_pkg::dp_status_type status,
   output ctrie_pkg::ctl_cmd_type   cmd
);
   import ctrie_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_CLEAR,
      S_COUNT,
      S_EMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd         = '0;
      cmd.capture = (state_ff == S_IDLE) && req_valid && req_ready_ff;
      cmd.lookup  = (state_ff == S_LOOKUP);
      cmd.clear   = (state_ff == S_CLEAR);
      cmd.count   = (state_ff == S_COUNT);
      cmd.emit    = (state_ff == S_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !cmd.emit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd.capture) begin
                  state_ff     <= S_LOOKUP;
                  req_ready_ff <= 1'b0;
               end
            end
            S_LOOKUP: begin
               if (status.alloc) begin
                  state_ff <= S_CLEAR;
               end else if (status.last) begin
                  state_ff <= status.live ? S_COUNT : S_EMIT;
               end else begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            S_CLEAR: begin
               if (status.last) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            S_COUNT: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (cmd.emit) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

// ===== rtl/ctrie_dp.sv =====
// Datapath of the counted trie engine: child-row and count memories,
// walk registers, node allocator and result registers. Depends on ctrie_pkg.
module ctrie_dp #(
   parameter int NODES      = ctrie_pkg::NODES_DEF,
   parameter int ALPHABET   = ctrie_pkg::ALPHABET_DEF,
   parameter int COUNT_BITS = ctrie_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ctrie_pkg::CMD_W-1:0]       req_command,
   input  logic [ctrie_pkg::LETTER_W-1:0]    req_letter,
   input  logic                              req_last,
   input  ctrie_pkg::ctl_cmd_type            cmd,
   output ctrie_pkg::dp_status_type          status,
   output logic                              rsp_present,
   output logic [ctrie_pkg::WCOUNT_W-1:0]    rsp_word_count,
   output logic                              rsp_pool_full
);
   import ctrie_pkg::*;

   localparam int NB = $clog2(NODES);
   localparam int LB = $clog2(ALPHABET);
   localparam int RW = ALPHABET * NB;

   logic [RW-1:0]         row_mem [NODES];
   logic [COUNT_BITS-1:0] cnt_mem [NODES];

   logic [CMD_W-1:0]      cmd_ff;
   logic [LETTER_W-1:0]   letter_ff;
   logic                  last_ff;
   logic [RW-1:0]         row_q_ff;
   logic [COUNT_BITS-1:0] cnt_q_ff;
   logic [NB-1:0]         cur_ff, cur_in;
   logic [NB-1:0]         next_free_ff, next_free_in;
   logic                  missed_ff, missed_in;
   logic                  failed_ff, failed_in;
   logic [COUNT_BITS-1:0] res_count_ff, res_count_in;
   logic                  res_full_ff, res_full_in;
   logic                  rsp_present_ff;
   logic [WCOUNT_W-1:0]   rsp_word_count_ff;
   logic                  rsp_pool_full_ff;

   logic [LB-1:0]         lidx;
   logic                  letter_ok;
   logic [NB-1:0]         child;
   logic [NB-1:0]         new_node;
   logic                  is_write;
   logic                  pool_empty;
   logic                  alloc;
   logic                  walk_live;
   logic                  row_we;
   logic [RW-1:0]         row_wd;
   logic                  cnt_we;
   logic [COUNT_BITS-1:0] cnt_wd;
   logic [COUNT_BITS-1:0] cnt_upd;
   logic [COUNT_BITS-1:0] cnt_init;

   assign lidx       = LB'(letter_ff);
   assign letter_ok  = 32'(letter_ff) < 32'(ALPHABET);
   assign child      = row_q_ff[lidx*NB +: NB];
   assign new_node   = next_free_ff + 1'b1;
   assign is_write   = (cmd_ff == CMD_INSERT) || (cmd_ff == CMD_DELETE);
   assign pool_empty = (next_free_ff == NB'(NODES - 1));
   assign cnt_init   = (last_ff && cmd_ff == CMD_INSERT) ? COUNT_BITS'(1) : '0;

   always_comb begin
      cnt_upd = cnt_q_ff;
      if (cmd_ff == CMD_INSERT) begin
         if (cnt_q_ff != '1) cnt_upd = cnt_q_ff + 1'b1;
      end else if (cmd_ff == CMD_DELETE) begin
         if (cnt_q_ff != '0) cnt_upd = cnt_q_ff - 1'b1;
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      next_free_in = next_free_ff;
      missed_in    = missed_ff;
      failed_in    = failed_ff;
      res_count_in = res_count_ff;
      res_full_in  = res_full_ff;
      alloc        = 1'b0;
      walk_live    = 1'b0;
      row_we       = 1'b0;
      row_wd       = row_q_ff;
      cnt_we       = 1'b0;
      cnt_wd       = cnt_upd;
      if (cmd.lookup) begin
         if (!missed_ff && !failed_ff) begin
            if (!letter_ok) begin
               missed_in = 1'b1;
            end else if (child != '0) begin
               cur_in = child;
            end else if (!is_write) begin
               missed_in = 1'b1;
            end else if (pool_empty) begin
               failed_in = 1'b1;
            end else begin
               alloc                   = 1'b1;
               next_free_in            = new_node;
               cur_in                  = new_node;
               row_we                  = 1'b1;
               row_wd[lidx*NB +: NB]   = new_node;
            end
         end
         walk_live = !missed_in && !failed_in;
         if (last_ff && (missed_in || failed_in)) begin
            res_count_in = '0;
            res_full_in  = failed_in;
            cur_in       = '0;
            missed_in    = 1'b0;
            failed_in    = 1'b0;
         end
      end
      if (cmd.clear) begin
         row_we = 1'b1;
         row_wd = '0;
         cnt_we = 1'b1;
         cnt_wd = cnt_init;
         if (last_ff) begin
            res_count_in = cnt_init;
            res_full_in  = 1'b0;
            cur_in       = '0;
         end
      end
      if (cmd.count) begin
         cnt_we       = 1'b1;
         cnt_wd       = cnt_upd;
         res_count_in = cnt_upd;
         res_full_in  = 1'b0;
         cur_in       = '0;
      end
   end

   assign status.alloc = alloc;
   assign status.last  = last_ff;
   assign status.live  = walk_live;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_q_ff <= row_mem[cur_ff];
      end
      if (reset) begin
         row_mem[0] <= '0;
      end else if (row_we) begin
         row_mem[cur_ff] <= row_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         cnt_q_ff <= cnt_mem[cur_in];
      end
      if (cnt_we) begin
         cnt_mem[cur_ff] <= cnt_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         next_free_ff <= '0;
         missed_ff    <= 1'b0;
         failed_ff    <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         next_free_ff <= next_free_in;
         missed_ff    <= missed_in;
         failed_ff    <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_command;
         letter_ff <= req_letter;
         last_ff   <= req_last;
      end
      res_count_ff <= res_count_in;
      res_full_ff  <= res_full_in;
      if (cmd.emit) begin
         rsp_present_ff    <= (res_count_ff != '0);
         rsp_word_count_ff <= WCOUNT_W'(res_count_ff);
         rsp_pool_full_ff  <= res_full_ff;
      end
   end

   assign rsp_present    = rsp_present_ff;
   assign rsp_word_count = rsp_word_count_ff;
   assign rsp_pool_full  = rsp_pool_full_ff;

endmodule

// ===== rtl/counted_trie_engine_top.sv =====
// Top level of the counted trie engine: joins controller and datapath.
// Depends on ctrie_pkg, ctrie_ctrl and ctrie_dp.
//
//   channel  direction  fields                                   transaction
//   req_     in         command[1:0] letter[4:0] last             one letter
//   rsp_     out        present word_count[15:0] pool_full        one word result
//
// A letter takes a child-row read, then a lookup, and a clear step when a node is
// handed out (its row is zeroed, its count set to one on the last letter of an
// insert and zeroed otherwise). A last letter adds a hand-off step and, when the
// walk hits an existing node, a count read-modify-write before it.
// Reset zeroes the root row; other rows are zeroed as nodes are allocated,
// so reset needs no clearing pass.
// A result waiting on rsp_ready does not block the next transaction until
// the following word ends.
module counted_trie_engine_top #(
   parameter int NODES      = ctrie_pkg::NODES_DEF,
   parameter int ALPHABET   = ctrie_pkg::ALPHABET_DEF,
   parameter int COUNT_BITS = ctrie_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ctrie_pkg::CMD_W-1:0]       req_command,
   input  logic [ctrie_pkg::LETTER_W-1:0]    req_letter,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_present,
   output logic [ctrie_pkg::WCOUNT_W-1:0]    rsp_word_count,
   output logic                              rsp_pool_full
);
   import ctrie_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   ctrie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ctrie_dp #(
      .NODES      (NODES),
      .ALPHABET   (ALPHABET),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_letter     (req_letter),
      .req_last       (req_last),
      .cmd            (cmd),
      .status         (status),
      .rsp_present    (rsp_present),
      .rsp_word_count (rsp_word_count),
      .rsp_pool_full  (rsp_pool_full)
   );

endmodule
